### rtl/tpsd_pkg.sv
// ---------------------------------------------------------------------------
// tpsd_pkg - shared types and constants of the TGA pixel stream decoder
// Register map, result status codes, configuration struct and setting check.
// ---------------------------------------------------------------------------
package tpsd_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned ADDR_WIDTH      = 4;
    localparam int unsigned TDATA_WIDTH     = 40;

    typedef enum logic [1:0] {
        REG_IMAGE_KIND  = 2'd0,
        REG_PIXEL_BYTES = 2'd1,
        REG_COMPRESSED  = 2'd2,
        REG_PIXEL_TOTAL = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_TRUE_COLOUR = 2'd0,
        KIND_GREY        = 2'd1,
        KIND_MAPPED      = 2'd2
    } t_kind;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNSUPP  = 2'd1;
    localparam logic [1:0] STATUS_CLIPPED = 2'd2;

    localparam logic [7:0] HDR_RUN_BIT   = 8'h80;
    localparam logic [7:0] HDR_COUNT_MSK = 8'h7F;

    typedef struct packed {
        logic [1:0]  image_kind;
        logic [2:0]  pixel_bytes;
        logic        compressed;
        logic        total_load;
        logic [31:0] pixel_total;
    } t_cfg;

    function automatic logic setting_ok(input logic [1:0] kind, input logic [2:0] nbytes);
        logic ok;
        begin
            case (kind)
                KIND_TRUE_COLOUR:      ok = (nbytes >= 3'd2) && (nbytes <= 3'd4);
                KIND_GREY, KIND_MAPPED: ok = (nbytes == 3'd1);
                default:               ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

### rtl/tpsd_regs.sv
// ---------------------------------------------------------------------------
// tpsd_regs - configuration register bank
// APB write/read of image kind, pixel bytes, compression mode and pixel total.
// ---------------------------------------------------------------------------
module tpsd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpsd_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output tpsd_pkg::t_cfg                o_cfg
);
    import tpsd_pkg::*;

    logic [1:0]  r_image_kind;
    logic [2:0]  r_pixel_bytes;
    logic        r_compressed;
    logic [31:0] r_pixel_total;
    logic        wr_en;
    t_reg_idx    idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_kind  <= 2'd0;
            r_pixel_bytes <= 3'd4;
            r_compressed  <= 1'b0;
            r_pixel_total <= 32'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_IMAGE_KIND:  r_image_kind  <= pwdata[1:0];
                REG_PIXEL_BYTES: r_pixel_bytes <= pwdata[2:0];
                REG_COMPRESSED:  r_compressed  <= pwdata[0];
                REG_PIXEL_TOTAL: r_pixel_total <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IMAGE_KIND:  prdata = {30'd0, r_image_kind};
            REG_PIXEL_BYTES: prdata = {29'd0, r_pixel_bytes};
            REG_COMPRESSED:  prdata = {31'd0, r_compressed};
            REG_PIXEL_TOTAL: prdata = r_pixel_total;
            default:         prdata = 32'd0;
        endcase
    end

    // load pulse carries the written value straight through to the countdown
    assign o_cfg.image_kind  = r_image_kind;
    assign o_cfg.pixel_bytes = r_pixel_bytes;
    assign o_cfg.compressed  = r_compressed;
    assign o_cfg.total_load  = wr_en && (idx == REG_PIXEL_TOTAL);
    assign o_cfg.pixel_total = pwdata;

endmodule

### rtl/tga_pixel_stream_decoder.sv
// ---------------------------------------------------------------------------
// tga_pixel_stream_decoder - TGA pixel data / RLE packet decoder
// Output: a result is registered and appears on the master side in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while the master side takes or holds no result;
// the state update and result register are a single registered step.
// Reset: synchronous, registers to defaults, countdown zero so bytes are
// dropped until pixel_total is written; writing it restarts at a header.
// ---------------------------------------------------------------------------
module tga_pixel_stream_decoder #(
    parameter int unsigned COUNT_WIDTH = tpsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tpsd_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] pixel_value, [39:32] repeat_length
    output logic [tpsd_pkg::TDATA_WIDTH-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,   // image_done
    output logic [1:0]                     m_axis_tuser    // [1:0] status
);
    import tpsd_pkg::*;

    typedef enum logic {PH_HEADER, PH_PIXEL} t_phase;

    t_cfg cfg;

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_bpos, n_bpos;
    logic [23:0]            r_asm, n_asm;
    logic [7:0]             r_pkt_left, n_pkt_left;
    logic                   r_pkt_run, n_pkt_run;
    logic [COUNT_WIDTH-1:0] r_pix_left, n_pix_left;
    logic                   r_err, n_err;

    logic                   r_valid;
    logic [31:0]            r_value, n_value;
    logic [7:0]             r_rep, n_rep;
    logic                   r_done, n_done;
    logic [1:0]             r_status, n_status;
    logic                   n_emit;

    logic                   accept;
    logic [31:0]            shifted;
    logic [31:0]            whole;
    logic [COUNT_WIDTH-1:0] rep_wide;
    logic [COUNT_WIDTH-1:0] left_after;

    tpsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready        = 1'b1;
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign shifted = {24'd0, s_axis_tdata} << {r_bpos, 3'b000};
    assign whole   = {8'd0, r_asm} | shifted;

    always_comb begin
        n_phase    = r_phase;
        n_bpos     = r_bpos;
        n_asm      = r_asm;
        n_pkt_left = r_pkt_left;
        n_pkt_run  = r_pkt_run;
        n_pix_left = r_pix_left;
        n_err      = r_err;
        n_emit     = 1'b0;
        n_value    = whole;
        n_rep      = 8'd1;
        n_done     = 1'b0;
        n_status   = STATUS_OK;
        rep_wide   = {{(COUNT_WIDTH-8){1'b0}}, r_pkt_left};
        left_after = r_pix_left;

        if (r_err || r_pix_left == '0) begin
            // idle or latched error: byte dropped
        end else if (!setting_ok(cfg.image_kind, cfg.pixel_bytes)) begin
            n_err    = 1'b1;
            n_emit   = 1'b1;
            n_value  = 32'd0;
            n_rep    = 8'd0;
            n_status = STATUS_UNSUPP;
        end else if (cfg.compressed && r_phase == PH_HEADER) begin
            n_pkt_run  = (s_axis_tdata & HDR_RUN_BIT) != 8'd0;
            n_pkt_left = (s_axis_tdata & HDR_COUNT_MSK) + 8'd1;
            n_phase    = PH_PIXEL;
            n_bpos     = 2'd0;
            n_asm      = 24'd0;
        end else if (({1'b0, r_bpos} + 3'd1) < cfg.pixel_bytes) begin
            n_asm  = r_asm | shifted[23:0];
            n_bpos = r_bpos + 2'd1;
        end else begin
            n_emit = 1'b1;
            n_bpos = 2'd0;
            n_asm  = 24'd0;
            if (cfg.image_kind == KIND_GREY) begin
                n_value = {8'd0, whole[7:0], whole[7:0], whole[7:0]};
            end
            if (cfg.compressed && r_pkt_run) begin
                if (rep_wide > r_pix_left) begin
                    n_rep      = r_pix_left[7:0];
                    n_status   = STATUS_CLIPPED;
                    left_after = '0;
                end else begin
                    n_rep      = r_pkt_left;
                    left_after = r_pix_left - rep_wide;
                end
                n_pkt_left = 8'd0;
                n_phase    = PH_HEADER;
            end else begin
                left_after = r_pix_left - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                if (cfg.compressed) begin
                    if (r_pkt_left > 8'd1 || r_pkt_left == 8'd0) begin
                        n_pkt_left = (r_pkt_left == 8'd0) ? 8'd0 : r_pkt_left - 8'd1;
                        if (r_pkt_left == 8'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_pkt_left = 8'd0;
                        n_phase    = PH_HEADER;
                    end
                end
            end
            n_pix_left = left_after;
            n_done     = (left_after == '0);
            if (left_after == '0) begin
                n_phase    = PH_HEADER;
                n_bpos     = 2'd0;
                n_asm      = 24'd0;
                n_pkt_left = 8'd0;
                n_pkt_run  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_bpos     <= 2'd0;
            r_asm      <= 24'd0;
            r_pkt_left <= 8'd0;
            r_pkt_run  <= 1'b0;
            r_pix_left <= '0;
            r_err      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (cfg.total_load) begin
                r_phase    <= PH_HEADER;
                r_bpos     <= 2'd0;
                r_asm      <= 24'd0;
                r_pkt_left <= 8'd0;
                r_pkt_run  <= 1'b0;
                r_pix_left <= cfg.pixel_total[COUNT_WIDTH-1:0];
            end else if (accept) begin
                r_phase    <= n_phase;
                r_bpos     <= n_bpos;
                r_asm      <= n_asm;
                r_pkt_left <= n_pkt_left;
                r_pkt_run  <= n_pkt_run;
                r_pix_left <= n_pix_left;
                r_err      <= n_err;
            end
            if (accept && n_emit) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_value  <= n_value;
            r_rep    <= n_rep;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_rep, r_value};
    assign m_axis_tlast  = r_done;
    assign m_axis_tuser  = r_status;

    a_err_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_UNSUPP) |-> (m_axis_tdata[39:32] == 8'd0))
        else $error("unsupported-setting transaction carries a repeat length");

    a_clip_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_CLIPPED) |-> m_axis_tlast)
        else $error("clipped run not marked as image end");

    a_last_empties_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_pix_left == '0))
        else $error("image end shown with pixels still outstanding");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

endmodule
